### design/dns_query_packet_classifier_core_defines.svh
// Assertion macros used by the classifier's output queue.
// They expect signals named clk and rst in the module that uses them.
`ifndef DNS_QUERY_PACKET_CLASSIFIER_CORE_DEFINES_SVH
`define DNS_QUERY_PACKET_CLASSIFIER_CORE_DEFINES_SVH

`define DNSQ_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`define DNSQ_ASSERT_IMPLY(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

`endif

### design/dnsq_pkg.sv
package dnsq_pkg;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_LEN,
    PH_CHARS,
    PH_TAIL
  } phase_t;

  localparam logic [2:0] V_OK     = 3'd0;
  localparam logic [2:0] V_NOTIP  = 3'd1;
  localparam logic [2:0] V_NOTUDP = 3'd2;
  localparam logic [2:0] V_PORT   = 3'd3;
  localparam logic [2:0] V_PARSE  = 3'd4;
  localparam logic [2:0] V_UNSUP  = 3'd5;

  localparam logic [5:0] POS_ETYPE_HI = 6'd12;
  localparam logic [5:0] POS_ETYPE_LO = 6'd13;
  localparam logic [5:0] POS_IHL      = 6'd14;
  localparam logic [5:0] POS_PROTO    = 6'd23;
  localparam logic [5:0] POS_IP_END   = 6'd33;
  localparam logic [5:0] POS_DPORT_HI = 6'd36;
  localparam logic [5:0] POS_DPORT_LO = 6'd37;
  localparam logic [5:0] POS_UDP_END  = 6'd41;
  localparam logic [5:0] POS_QDC_HI   = 6'd46;
  localparam logic [5:0] POS_QDC_LO   = 6'd47;
  localparam logic [5:0] POS_DNS_END  = 6'd53;
  localparam logic [5:0] POS_MIN_ETH  = 6'd14;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [3:0]  IHL_PLAIN      = 4'd5;
  localparam logic [15:0] PROTO_UDP      = 16'd17;
  localparam logic [15:0] QDCOUNT_ONE    = 16'd1;
  localparam logic [15:0] QTYPE_A        = 16'd1;
  localparam logic [15:0] QCLASS_IN      = 16'd1;

  localparam logic [7:0] LABEL_TOP_MASK = 8'hC0;
  localparam logic [7:0] LABEL_MAX      = 8'd63;
  localparam logic [7:0] CASE_OFFSET    = 8'd32;
  localparam logic [7:0] CHAR_DOT       = 8'h2E;
  localparam logic [8:0] QUESTION_FIXED = 9'd16;

  localparam int QDEPTH = 4;

  typedef struct packed {
    logic        kind;
    logic [7:0]  name_char;
    logic [2:0]  verdict;
    logic [15:0] query_type;
    logic [15:0] query_class;
    logic [7:0]  name_length;
    logic [8:0]  question_length;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [1:0] n;
    res_t       a;
    res_t       b;
  } push_t;

endpackage

### design/dnsq_parser.sv
module dnsq_parser import dnsq_pkg::*; #(
  parameter int NAME_MAX    = 256,
  parameter int LABEL_SLOTS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic [15:0] udp_port,
  output push_t       push
);

  localparam int NCW = $clog2(NAME_MAX);
  localparam int LCW = $clog2(LABEL_SLOTS + 1);

  logic [5:0]     hdr_pos, hdr_pos_next;
  phase_t         phase, phase_next;
  logic [15:0]    field_shift, field_shift_next;
  logic [5:0]     label_rem, label_rem_next;
  logic [LCW-1:0] label_cnt, label_cnt_next;
  logic [NCW-1:0] name_cnt, name_cnt_next;
  logic [8:0]     bytes_used, bytes_used_next;
  logic [15:0]    type_seen, type_seen_next;
  logic [15:0]    class_seen, class_seen_next;
  logic [2:0]     dec_verdict, dec_verdict_next;
  logic           dec_flag, dec_flag_next;

  always_comb begin
    logic        name_full;
    logic [7:0]  ch;
    logic        emit;
    logic [7:0]  emit_char;
    logic [2:0]  v;
    res_t        chr;
    res_t        fin;

    hdr_pos_next     = hdr_pos;
    phase_next       = phase;
    field_shift_next = field_shift;
    label_rem_next   = label_rem;
    label_cnt_next   = label_cnt;
    name_cnt_next    = name_cnt;
    bytes_used_next  = bytes_used;
    type_seen_next   = type_seen;
    class_seen_next  = class_seen;
    dec_verdict_next = dec_verdict;
    dec_flag_next    = dec_flag;
    emit             = 1'b0;
    emit_char        = CHAR_DOT;
    name_full = ({1'b0, name_cnt} + (NCW+1)'(1)) >= (NCW+1)'(NAME_MAX);
    ch = data_byte;
    if (ch inside {[8'h41:8'h5A]}) begin
      ch = ch + CASE_OFFSET;
    end

    if (!dec_flag) begin
      case (phase)
        PH_HEADER: begin
          hdr_pos_next = hdr_pos + 6'd1;
          case (hdr_pos)
            POS_ETYPE_HI, POS_DPORT_HI, POS_QDC_HI, POS_PROTO: begin
              field_shift_next = {8'd0, data_byte};
            end
            POS_DPORT_LO, POS_QDC_LO: begin
              field_shift_next = {field_shift[7:0], data_byte};
            end
            POS_ETYPE_LO: begin
              if ({field_shift[7:0], data_byte} != ETHERTYPE_IPV4) begin
                dec_flag_next    = 1'b1;
                dec_verdict_next = V_NOTIP;
              end
            end
            POS_IHL: begin
              if (data_byte[3:0] != IHL_PLAIN) begin
                dec_flag_next    = 1'b1;
                dec_verdict_next = V_PARSE;
              end
            end
            POS_IP_END: begin
              if (field_shift != PROTO_UDP) begin
                dec_flag_next    = 1'b1;
                dec_verdict_next = V_NOTUDP;
              end
            end
            POS_UDP_END: begin
              if (field_shift != udp_port) begin
                dec_flag_next    = 1'b1;
                dec_verdict_next = V_PORT;
              end
            end
            POS_DNS_END: begin
              if (field_shift != QDCOUNT_ONE) begin
                dec_flag_next    = 1'b1;
                dec_verdict_next = V_UNSUP;
              end else begin
                phase_next = PH_LEN;
              end
            end
            default: begin
            end
          endcase
        end
        PH_LEN: begin
          if (label_cnt >= LCW'(LABEL_SLOTS)) begin
            dec_flag_next    = 1'b1;
            dec_verdict_next = V_PARSE;
          end else begin
            label_cnt_next  = label_cnt + LCW'(1);
            bytes_used_next = bytes_used + 9'd1;
            if (data_byte == 8'd0) begin
              phase_next     = PH_TAIL;
              label_rem_next = 6'd0;
            end else if ((data_byte & LABEL_TOP_MASK) != 8'd0 || data_byte > LABEL_MAX) begin
              dec_flag_next    = 1'b1;
              dec_verdict_next = V_PARSE;
            end else if (label_cnt != '0 && name_full) begin
              dec_flag_next    = 1'b1;
              dec_verdict_next = V_PARSE;
            end else begin
              if (label_cnt != '0) begin
                emit          = 1'b1;
                emit_char     = CHAR_DOT;
                name_cnt_next = name_cnt + NCW'(1);
              end
              label_rem_next = data_byte[5:0];
              phase_next     = PH_CHARS;
            end
          end
        end
        PH_CHARS: begin
          bytes_used_next = bytes_used + 9'd1;
          if (name_full) begin
            dec_flag_next    = 1'b1;
            dec_verdict_next = V_PARSE;
          end else begin
            emit           = 1'b1;
            emit_char      = ch;
            name_cnt_next  = name_cnt + NCW'(1);
            label_rem_next = label_rem - 6'd1;
            if (label_rem == 6'd1) begin
              phase_next = PH_LEN;
            end
          end
        end
        PH_TAIL: begin
          label_rem_next = label_rem + 6'd1;
          case (label_rem)
            6'd0: type_seen_next = {data_byte, 8'd0};
            6'd1: type_seen_next = {type_seen[15:8], data_byte};
            6'd2: class_seen_next = {data_byte, 8'd0};
            default: begin
              class_seen_next  = {class_seen[15:8], data_byte};
              bytes_used_next  = bytes_used + QUESTION_FIXED;
              dec_flag_next    = 1'b1;
              dec_verdict_next = (type_seen == QTYPE_A && class_seen_next == QCLASS_IN) ?
                                 V_OK : V_UNSUP;
            end
          endcase
        end
        default: begin
        end
      endcase
    end

    if (dec_flag_next) begin
      v = dec_verdict_next;
    end else if (phase_next == PH_HEADER && hdr_pos_next < POS_MIN_ETH) begin
      v = V_NOTIP;
    end else begin
      v = V_PARSE;
    end

    chr = '0;
    chr.name_char = emit_char;

    fin = '0;
    fin.kind            = 1'b1;
    fin.verdict         = v;
    fin.query_type      = type_seen_next;
    fin.query_class     = class_seen_next;
    fin.name_length     = 8'(name_cnt_next);
    fin.question_length = (v == V_OK || v == V_UNSUP) ? bytes_used_next : 9'd0;
    fin.last            = 1'b1;

    push.a = emit ? chr : fin;
    push.b = fin;
    push.n = 2'd0;
    if (step) begin
      push.n = 2'(emit) + 2'(last_byte);
    end

    if (last_byte) begin
      hdr_pos_next     = 6'd0;
      phase_next       = PH_HEADER;
      field_shift_next = 16'd0;
      label_rem_next   = 6'd0;
      label_cnt_next   = '0;
      name_cnt_next    = '0;
      bytes_used_next  = 9'd0;
      type_seen_next   = 16'd0;
      class_seen_next  = 16'd0;
      dec_verdict_next = V_OK;
      dec_flag_next    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_pos     <= 6'd0;
      phase       <= PH_HEADER;
      field_shift <= 16'd0;
      label_rem   <= 6'd0;
      label_cnt   <= '0;
      name_cnt    <= '0;
      bytes_used  <= 9'd0;
      type_seen   <= 16'd0;
      class_seen  <= 16'd0;
      dec_verdict <= V_OK;
      dec_flag    <= 1'b0;
    end else if (step) begin
      hdr_pos     <= hdr_pos_next;
      phase       <= phase_next;
      field_shift <= field_shift_next;
      label_rem   <= label_rem_next;
      label_cnt   <= label_cnt_next;
      name_cnt    <= name_cnt_next;
      bytes_used  <= bytes_used_next;
      type_seen   <= type_seen_next;
      class_seen  <= class_seen_next;
      dec_verdict <= dec_verdict_next;
      dec_flag    <= dec_flag_next;
    end
  end

endmodule

### design/dnsq_out_queue.sv
module dnsq_out_queue import dnsq_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  push_t push,
  output logic  space,
  output logic  out_valid,
  input  logic  out_ready,
  output res_t  head
);

  `include "dns_query_packet_classifier_core_defines.svh"

  res_t       q [QDEPTH];
  res_t       q_next [QDEPTH];
  logic [2:0] cnt, cnt_next;
  logic       pop;
  logic [2:0] base;

  always_comb begin
    pop  = (cnt != 3'd0) && out_ready;
    base = pop ? cnt - 3'd1 : cnt;
    for (int i = 0; i < QDEPTH; i++) begin
      q_next[i] = q[i];
    end
    if (pop) begin
      for (int i = 0; i < QDEPTH - 1; i++) begin
        q_next[i] = q[i+1];
      end
    end
    for (int i = 0; i < QDEPTH; i++) begin
      if (push.n != 2'd0 && base == 3'(i)) begin
        q_next[i] = push.a;
      end
      if (push.n == 2'd2 && base + 3'd1 == 3'(i)) begin
        q_next[i] = push.b;
      end
    end
    cnt_next = cnt - 3'(pop) + 3'(push.n);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 3'd0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QDEPTH; i++) begin
      q[i] <= q_next[i];
    end
  end

  assign space     = cnt <= 3'(QDEPTH - 2);
  assign out_valid = cnt != 3'd0;
  assign head      = q[0];

  `DNSQ_ASSERT_IMPLY(a_push_space, push.n != 2'd0, cnt <= 3'(QDEPTH - 2), "push without room")
  `DNSQ_ASSERT_IMPLY(a_pair_order, push.n == 2'd2, !push.a.kind && push.b.kind, "pair out of order")
  `DNSQ_ASSERT_IMPLY(a_head_last, cnt != 3'd0, q[0].kind == q[0].last, "verdict without last")
  `DNSQ_ASSERT_ALWAYS(a_cnt_bound, cnt <= 3'(QDEPTH), "queue count overflow")

endmodule

### design/dns_query_packet_classifier_core.sv
// A byte accepted into the input register is parsed once the result queue has room,
// and its results are written into the result queue, from which they can be taken.
// Throughput: one byte per cycle while the result queue has room; a frame's last byte
// that also emits a name character or dot gives two beats, which the four-entry result
// queue absorbs.
// Reset (rst, synchronous): frame state and the result queue clear, udp_port is 53.
module dns_query_packet_classifier_core import dnsq_pkg::*; #(
  parameter int NAME_MAX    = 256,
  parameter int LABEL_SLOTS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        kind,
  output logic [7:0]  name_char,
  output logic [2:0]  verdict,
  output logic [15:0] query_type,
  output logic [15:0] query_class,
  output logic [7:0]  name_length,
  output logic [8:0]  question_length,
  output logic        last
);

  logic [15:0] udp_port;
  logic        ivalid;
  logic [7:0]  ibyte;
  logic        ilast;
  logic        space;
  logic        fire;
  push_t       push;
  res_t        head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      udp_port <= 16'd53;
    end else if (cfg_valid) begin
      udp_port <= cfg_data;
    end
  end

  assign fire     = ivalid && space;
  assign in_ready = !ivalid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      ivalid <= 1'b0;
    end else if (in_ready) begin
      ivalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ibyte <= data_byte;
      ilast <= last_byte;
    end
  end

  dnsq_parser #(
    .NAME_MAX    (NAME_MAX),
    .LABEL_SLOTS (LABEL_SLOTS)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (fire),
    .data_byte (ibyte),
    .last_byte (ilast),
    .udp_port  (udp_port),
    .push      (push)
  );

  dnsq_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign kind            = head.kind;
  assign name_char       = head.name_char;
  assign verdict         = head.verdict;
  assign query_type      = head.query_type;
  assign query_class     = head.query_class;
  assign name_length     = head.name_length;
  assign question_length = head.question_length;
  assign last            = head.last;

endmodule

### verif/tb.sv
`timescale 1ns / 100ps

module tb;
  import dnsq_pkg::*;

  localparam int NAME_MAX = 256;
  localparam int LABEL_SLOTS = 32;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_BYTES = 400;
  localparam logic [15:0] PORT_AT_RESET = 16'd53;
  localparam logic [7:0] VER_IHL_OK = {4'h4, IHL_PLAIN};
  localparam logic [7:0] UDP_PROTO = PROTO_UDP[7:0];

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } frame_byte_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = '0;
  logic        last_byte = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        kind;
  logic [7:0]  name_char;
  logic [2:0]  verdict;
  logic [15:0] query_type;
  logic [15:0] query_class;
  logic [7:0]  name_length;
  logic [8:0]  question_length;
  logic        last;

  dns_query_packet_classifier_core #(
    .NAME_MAX(NAME_MAX),
    .LABEL_SLOTS(LABEL_SLOTS)
  ) dut (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  frame_byte_t frame_bytes[$];
  logic [7:0]  frame_buf[$];
  res_t        results_due[$];
  int          bytes_queued = 0;
  int          mismatches = 0;
  int          cycle_count = 0;
  bit          idle_allowed = 1'b1;
  int          gap_pct = 0;
  int          stall_pct = 0;
  int          mood_left = 0;
  int          gap_left = 0;
  int          stall_left = 0;

  // Classifier state as the block should hold it.
  logic [15:0] port_setting = PORT_AT_RESET;
  logic [5:0]  hdr_pos;
  phase_t      phase;
  logic [15:0] shift_reg;
  logic [5:0]  label_left;
  logic [5:0]  labels_seen;
  logic [7:0]  chars_out;
  logic [8:0]  q_bytes;
  logic [15:0] qtype_r;
  logic [15:0] qclass_r;
  logic [2:0]  verdict_r;
  logic        decided;

  function automatic void clear_frame();
    hdr_pos = '0;
    phase = PH_HEADER;
    shift_reg = '0;
    label_left = '0;
    labels_seen = '0;
    chars_out = '0;
    q_bytes = '0;
    qtype_r = '0;
    qclass_r = '0;
    verdict_r = V_OK;
    decided = 1'b0;
  endfunction

  function automatic void decide_frame(logic [2:0] v);
    verdict_r = v;
    decided = 1'b1;
  endfunction

  function automatic void push_char(logic [7:0] c);
    res_t r;
    r = '0;
    r.name_char = c;
    results_due.push_back(r);
    chars_out = chars_out + 1'b1;
  endfunction

  function automatic void classify_byte(logic [7:0] b, logic fin);
    logic [7:0] c;
    logic [2:0] v;
    res_t r;
    if (!decided) begin
      case (phase)
        PH_HEADER: begin
          case (hdr_pos)
            POS_ETYPE_HI, POS_PROTO, POS_DPORT_HI, POS_QDC_HI: shift_reg = {8'h00, b};
            POS_ETYPE_LO: if ({shift_reg[7:0], b} != ETHERTYPE_IPV4) decide_frame(V_NOTIP);
            POS_IHL: if (b[3:0] != IHL_PLAIN) decide_frame(V_PARSE);
            POS_IP_END: if (shift_reg != PROTO_UDP) decide_frame(V_NOTUDP);
            POS_DPORT_LO, POS_QDC_LO: shift_reg = {shift_reg[7:0], b};
            POS_UDP_END: if (shift_reg != port_setting) decide_frame(V_PORT);
            POS_DNS_END: begin
              if (shift_reg != QDCOUNT_ONE) decide_frame(V_UNSUP);
              else phase = PH_LEN;
            end
            default: ;
          endcase
          hdr_pos = hdr_pos + 1'b1;
        end
        PH_LEN: begin
          if (labels_seen >= LABEL_SLOTS) begin
            decide_frame(V_PARSE);
          end else begin
            labels_seen = labels_seen + 1'b1;
            q_bytes = q_bytes + 1'b1;
            if (b == 8'h00) begin
              phase = PH_TAIL;
              label_left = '0;
            end else if ((b & LABEL_TOP_MASK) != 8'h00 || b > LABEL_MAX) begin
              decide_frame(V_PARSE);
            end else if (labels_seen > 1 && int'(chars_out) + 1 >= NAME_MAX) begin
              decide_frame(V_PARSE);
            end else begin
              if (labels_seen > 1) push_char(CHAR_DOT);
              label_left = b[5:0];
              phase = PH_CHARS;
            end
          end
        end
        PH_CHARS: begin
          q_bytes = q_bytes + 1'b1;
          c = (b >= "A" && b <= "Z") ? b + CASE_OFFSET : b;
          if (int'(chars_out) + 1 >= NAME_MAX) begin
            decide_frame(V_PARSE);
          end else begin
            push_char(c);
            label_left = label_left - 1'b1;
            if (label_left == 0) phase = PH_LEN;
          end
        end
        default: begin
          case (label_left)
            6'd0: qtype_r = {b, 8'h00};
            6'd1: qtype_r = qtype_r | {8'h00, b};
            6'd2: qclass_r = {b, 8'h00};
            default: begin
              qclass_r = qclass_r | {8'h00, b};
              q_bytes = q_bytes + QUESTION_FIXED;
              decide_frame((qtype_r == QTYPE_A && qclass_r == QCLASS_IN) ? V_OK : V_UNSUP);
            end
          endcase
          label_left = label_left + 1'b1;
        end
      endcase
    end
    if (fin) begin
      if (decided) v = verdict_r;
      else if (phase == PH_HEADER && hdr_pos < POS_MIN_ETH) v = V_NOTIP;
      else v = V_PARSE;
      r = '0;
      r.kind = 1'b1;
      r.verdict = v;
      r.query_type = qtype_r;
      r.query_class = qclass_r;
      r.name_length = chars_out;
      r.question_length = (v == V_OK || v == V_UNSUP) ? q_bytes : 9'd0;
      r.last = 1'b1;
      results_due.push_back(r);
      clear_frame();
    end
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(3))
      0: return 0;
      1: return 5;
      2: return 20;
      default: return 50;
    endcase
  endfunction

  always @(posedge clk) begin
    if (mood_left != 0) begin
      mood_left <= mood_left - 1;
    end else begin
      mood_left <= $urandom_range(400, 40);
      gap_pct <= pick_pct();
      stall_pct <= pick_pct();
    end
  end

  always @(posedge clk) begin
    frame_byte_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
      clear_frame();
    end else begin
      if (in_valid && in_ready) classify_byte(data_byte, last_byte);
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (frame_bytes.size() != 0 && idle_allowed &&
                     $urandom_range(99) < gap_pct) begin
          gap_left <= $urandom_range(15, 0);
          in_valid <= 1'b0;
        end else if (frame_bytes.size() != 0) begin
          nxt = frame_bytes.pop_front();
          in_valid <= 1'b1;
          data_byte <= nxt.data;
          last_byte <= nxt.fin;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic report_beat(string why, res_t want, res_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s: expected kind %0d char %02h verdict %0d type %04h class %04h",
               why, want.kind, want.name_char, want.verdict, want.query_type,
               want.query_class);
      $display("  name_len %0d q_len %0d last %0d; got kind %0d char %02h verdict %0d",
               want.name_length, want.question_length, want.last, got.kind,
               got.name_char, got.verdict);
      $display("  type %04h class %04h name_len %0d q_len %0d last %0d",
               got.query_type, got.query_class, got.name_length,
               got.question_length, got.last);
    end
  endtask

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        got = {kind, name_char, verdict, query_type, query_class, name_length,
               question_length, last};
        if (results_due.size() == 0) begin
          report_beat("beat with nothing expected", '0, got);
        end else begin
          want = results_due.pop_front();
          if (got.kind !== want.kind || got.name_char !== want.name_char ||
              got.verdict !== want.verdict || got.query_type !== want.query_type ||
              got.query_class !== want.query_class ||
              got.name_length !== want.name_length ||
              got.question_length !== want.question_length || got.last !== want.last)
            report_beat("beat mismatch", want, got);
        end
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_ready <= 1'b0;
      end else if (idle_allowed && $urandom_range(99) < stall_pct) begin
        stall_left <= $urandom_range(15, 0);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic [7:0] pick_name_byte();
    case ($urandom_range(3))
      0: return 8'("A" + $urandom_range(25));
      1: return 8'("a" + $urandom_range(25));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Builds the 54 bytes of Ethernet, IPv4, UDP and DNS headers.
  task automatic start_frame(logic [15:0] etype, logic [7:0] ver_ihl, logic [7:0] proto,
                             logic [15:0] dport, logic [15:0] qdc);
    frame_buf.delete();
    repeat (12) frame_buf.push_back(8'($urandom_range(255)));
    frame_buf.push_back(etype[15:8]);
    frame_buf.push_back(etype[7:0]);
    frame_buf.push_back(ver_ihl);
    repeat (8) frame_buf.push_back(8'($urandom_range(255)));
    frame_buf.push_back(proto);
    repeat (12) frame_buf.push_back(8'($urandom_range(255)));
    frame_buf.push_back(dport[15:8]);
    frame_buf.push_back(dport[7:0]);
    repeat (8) frame_buf.push_back(8'($urandom_range(255)));
    frame_buf.push_back(qdc[15:8]);
    frame_buf.push_back(qdc[7:0]);
    repeat (6) frame_buf.push_back(8'($urandom_range(255)));
  endtask

  task automatic add_label(int len);
    frame_buf.push_back(8'(len));
    repeat (len) frame_buf.push_back(pick_name_byte());
  endtask

  task automatic finish_question(logic [15:0] qt, logic [15:0] qc);
    frame_buf.push_back(8'h00);
    frame_buf.push_back(qt[15:8]);
    frame_buf.push_back(qt[7:0]);
    frame_buf.push_back(qc[15:8]);
    frame_buf.push_back(qc[7:0]);
  endtask

  // Queues the first keep bytes of the frame; zero or too large means all of it.
  task automatic send_frame(int keep);
    int n;
    frame_byte_t fb;
    n = (keep <= 0 || keep > frame_buf.size()) ? frame_buf.size() : keep;
    for (int i = 0; i < n; i++) begin
      fb = {frame_buf[i], (i == n - 1)};
      frame_bytes.push_back(fb);
    end
    bytes_queued += n;
  endtask

  task automatic random_frame();
    int pick;
    int count;
    int keep;
    logic [15:0] etype;
    logic [15:0] dport;
    logic [15:0] qdc;
    logic [15:0] qt;
    logic [15:0] qc;
    logic [7:0] ver_ihl;
    logic [7:0] proto;
    pick = $urandom_range(99);
    keep = 0;
    etype = ETHERTYPE_IPV4;
    ver_ihl = 8'(($urandom_range(15) << 4) | IHL_PLAIN);
    proto = UDP_PROTO;
    dport = port_setting;
    qdc = QDCOUNT_ONE;
    qt = QTYPE_A;
    qc = QCLASS_IN;
    if ($urandom_range(3) == 0) begin
      qt = 16'($urandom_range(65535));
      qc = $urandom_range(1) ? QCLASS_IN : 16'($urandom_range(65535));
    end
    if (pick >= 94) begin
      frame_buf.delete();
      repeat ($urandom_range(24, 1)) frame_buf.push_back(8'($urandom_range(255)));
      send_frame(0);
      return;
    end
    if (pick >= 60 && pick < 65) begin
      etype = 16'($urandom_range(65535));
      if (etype == ETHERTYPE_IPV4) etype = ~etype;
    end else if (pick >= 65 && pick < 69) begin
      ver_ihl[3:0] = IHL_PLAIN ^ 4'($urandom_range(15, 1));
    end else if (pick >= 69 && pick < 73) begin
      proto = UDP_PROTO ^ 8'($urandom_range(255, 1));
    end else if (pick >= 73 && pick < 78) begin
      dport = port_setting ^ 16'($urandom_range(65535, 1));
    end else if (pick >= 78 && pick < 82) begin
      qdc = QDCOUNT_ONE ^ 16'($urandom_range(65535, 1));
    end
    start_frame(etype, ver_ihl, proto, dport, qdc);
    if (pick >= 91) begin
      if ($urandom_range(1) != 0) repeat ($urandom_range(6, 3)) add_label($urandom_range(63, 40));
      else repeat ($urandom_range(34, 28)) add_label($urandom_range(2, 1));
    end else begin
      count = ($urandom_range(9) == 0) ? 0 : $urandom_range(4, 1);
      repeat (count) add_label($urandom_range(12, 1));
      if (pick >= 82 && pick < 86) begin
        frame_buf.push_back(8'($urandom_range(255, 64)));
        repeat (3) frame_buf.push_back(8'($urandom_range(255)));
      end
    end
    finish_question(qt, qc);
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(6, 1)) frame_buf.push_back(8'($urandom_range(255)));
    end
    if (pick >= 86 && pick < 91) keep = $urandom_range(frame_buf.size() - 1, 1);
    send_frame(keep);
  endtask

  // Looks at the queues between edges, after the clocked blocks have settled.
  task automatic drain(int settle);
    while (frame_bytes.size() != 0 || in_valid || results_due.size() != 0) @(negedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic set_udp_port(logic [15:0] p);
    drain(4);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= p;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    port_setting = p;
  endtask

  initial begin
    logic [7:0] bad_len [3];
    logic [15:0] port_plan [4];
    bad_len = '{8'h40, 8'h80, 8'hC0};
    port_plan = '{16'h0000, 16'hFFFF, 16'h0000, PORT_AT_RESET};
    port_plan[2] = 16'($urandom_range(65535));
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    start_frame(ETHERTYPE_IPV4, VER_IHL_OK, UDP_PROTO, port_setting, QDCOUNT_ONE);
    add_label(3);
    add_label(7);
    add_label(3);
    finish_question(QTYPE_A, QCLASS_IN);
    send_frame(0);
    start_frame(ETHERTYPE_IPV4, VER_IHL_OK, UDP_PROTO, port_setting, QDCOUNT_ONE);
    finish_question(QTYPE_A, QCLASS_IN);
    send_frame(0);
    start_frame(ETHERTYPE_IPV4, VER_IHL_OK, UDP_PROTO, port_setting, QDCOUNT_ONE);
    add_label(int'(LABEL_MAX));
    add_label(1);
    finish_question(16'hFFFF, 16'h0000);
    send_frame(0);
    start_frame(ETHERTYPE_IPV4, VER_IHL_OK, UDP_PROTO, port_setting, QDCOUNT_ONE);
    add_label(2);
    finish_question(16'h0000, 16'hFFFF);
    send_frame(0);
    start_frame(ETHERTYPE_IPV4, VER_IHL_OK, UDP_PROTO, port_setting, QDCOUNT_ONE);
    add_label(4);
    finish_question(QTYPE_A, QCLASS_IN);
    repeat (5) frame_buf.push_back(8'($urandom_range(255)));
    send_frame(0);
    // Frames that end inside the Ethernet header or right after it.
    start_frame(ETHERTYPE_IPV4, VER_IHL_OK, UDP_PROTO, port_setting, QDCOUNT_ONE);
    send_frame(1);
    start_frame(ETHERTYPE_IPV4, VER_IHL_OK, UDP_PROTO, port_setting, QDCOUNT_ONE);
    send_frame(13);
    start_frame(ETHERTYPE_IPV4, VER_IHL_OK, UDP_PROTO, port_setting, QDCOUNT_ONE);
    send_frame(14);
    start_frame(16'h86DD, VER_IHL_OK, UDP_PROTO, port_setting, QDCOUNT_ONE);
    add_label(2);
    finish_question(QTYPE_A, QCLASS_IN);
    send_frame(0);
    start_frame(ETHERTYPE_IPV4, 8'h46, UDP_PROTO, port_setting, QDCOUNT_ONE);
    add_label(2);
    finish_question(QTYPE_A, QCLASS_IN);
    send_frame(0);
    // The IP version nibble is not checked.
    start_frame(ETHERTYPE_IPV4, 8'h65, UDP_PROTO, port_setting, QDCOUNT_ONE);
    add_label(2);
    finish_question(QTYPE_A, QCLASS_IN);
    send_frame(0);
    start_frame(ETHERTYPE_IPV4, VER_IHL_OK, 8'd6, port_setting, QDCOUNT_ONE);
    add_label(2);
    finish_question(QTYPE_A, QCLASS_IN);
    send_frame(0);
    start_frame(ETHERTYPE_IPV4, VER_IHL_OK, UDP_PROTO, port_setting ^ 16'h0001, QDCOUNT_ONE);
    add_label(2);
    finish_question(QTYPE_A, QCLASS_IN);
    send_frame(0);
    start_frame(ETHERTYPE_IPV4, VER_IHL_OK, UDP_PROTO, port_setting, 16'h0000);
    add_label(2);
    finish_question(QTYPE_A, QCLASS_IN);
    send_frame(0);
    start_frame(ETHERTYPE_IPV4, VER_IHL_OK, UDP_PROTO, port_setting, 16'h0002);
    add_label(2);
    finish_question(QTYPE_A, QCLASS_IN);
    send_frame(0);
    for (int k = 0; k < 3; k++) begin
      start_frame(ETHERTYPE_IPV4, VER_IHL_OK, UDP_PROTO, port_setting, QDCOUNT_ONE);
      add_label(3);
      frame_buf.push_back(bad_len[k]);
      add_label(2);
      finish_question(QTYPE_A, QCLASS_IN);
      send_frame(0);
    end
    // The largest label count that fits, then one more.
    for (int k = LABEL_SLOTS - 1; k <= LABEL_SLOTS; k++) begin
      start_frame(ETHERTYPE_IPV4, VER_IHL_OK, UDP_PROTO, port_setting, QDCOUNT_ONE);
      repeat (k) add_label(1);
      finish_question(QTYPE_A, QCLASS_IN);
      send_frame(0);
    end
    // Overlong names: the first overflows on a dot, the second on a character.
    start_frame(ETHERTYPE_IPV4, VER_IHL_OK, UDP_PROTO, port_setting, QDCOUNT_ONE);
    repeat (4) add_label(int'(LABEL_MAX));
    add_label(2);
    finish_question(QTYPE_A, QCLASS_IN);
    send_frame(0);
    start_frame(ETHERTYPE_IPV4, VER_IHL_OK, UDP_PROTO, port_setting, QDCOUNT_ONE);
    repeat (3) add_label(int'(LABEL_MAX));
    add_label(int'(LABEL_MAX) - 1);
    add_label(2);
    finish_question(QTYPE_A, QCLASS_IN);
    send_frame(0);
    // Truncation on a name character, on a length byte that adds a dot, and in QTYPE.
    start_frame(ETHERTYPE_IPV4, VER_IHL_OK, UDP_PROTO, port_setting, QDCOUNT_ONE);
    add_label(5);
    add_label(5);
    send_frame(57);
    start_frame(ETHERTYPE_IPV4, VER_IHL_OK, UDP_PROTO, port_setting, QDCOUNT_ONE);
    add_label(5);
    add_label(5);
    send_frame(61);
    start_frame(ETHERTYPE_IPV4, VER_IHL_OK, UDP_PROTO, port_setting, QDCOUNT_ONE);
    add_label(3);
    finish_question(QTYPE_A, QCLASS_IN);
    send_frame(frame_buf.size() - 2);

    for (int k = 0; k < 4; k++) begin
      set_udp_port(port_plan[k]);
      if (k == 3) idle_allowed = 1'b0;
      bytes_queued = 0;
      while (bytes_queued < PHASE_BYTES) random_frame();
    end

    drain(10);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
